// ===== design/hdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants for the HTTP body dechunker
// Codes, parse phases, the request beat struct and the byte classifiers.
// ----------------------------------------------------------------------------
package hdc_pkg;

   localparam int LINE_LIMIT_DEF = 2048;
   localparam int COUNT_BITS_DEF = 32;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 31;
   localparam int LEN_W       = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMING_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BODY_LENGTH  = 8'd1;

   localparam logic [1:0] MODE_FIXED   = 2'd0;
   localparam logic [1:0] MODE_CHUNKED = 2'd1;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_BODY     = 2'd1;
   localparam logic [1:0] ST_COMPLETE = 2'd2;
   localparam logic [1:0] ST_ABORT    = 2'd3;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [LEN_W-1:0] SIZE_MAX_MAG = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      PH_LINE,
      PH_DATA,
      PH_TRAILER
   } phase_type;

   typedef enum logic [2:0] {
      PS_BLANK,
      PS_SIGN,
      PS_ZERO,
      PS_PREFIX,
      PS_DIGITS,
      PS_STOP
   } step_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } req_beat_type;

   // 16 means "not a hex digit"
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b inside {[8'h30:8'h39]}) begin
         v = 5'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         v = 5'(b - 8'h57);
      end else if (b inside {[8'h41:8'h46]}) begin
         v = 5'(b - 8'h37);
      end
      return v;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage

// ===== design/hdc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_in_reg: request input register
// Holds one request beat; refills in the same cycle the core takes it.
// ----------------------------------------------------------------------------
module hdc_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  hdc_pkg::req_beat_type req_beat,
   output logic                 beat_valid,
   output hdc_pkg::req_beat_type beat,
   input  logic                 beat_ready
);

   logic                  valid_ff;
   logic                  valid_in;
   hdc_pkg::req_beat_type beat_ff;

   assign req_tready = !valid_ff || beat_ready;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// ===== design/hdc_size_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_size_parse: chunk size line digit parser
// One byte of strtol-style base 16 parsing: blanks, sign, 0x, hex digits.
// ----------------------------------------------------------------------------
module hdc_size_parse (
   input  hdc_pkg::step_type             step,
   input  logic [hdc_pkg::LEN_W-1:0]     acc,
   input  logic                          negative,
   input  logic [7:0]                    rx_byte,
   output hdc_pkg::step_type             step_out,
   output logic [hdc_pkg::LEN_W-1:0]     acc_out,
   output logic                          negative_out
);

   logic [4:0]                  digit;
   logic                        is_digit;
   logic [hdc_pkg::LEN_W-1:0]   acc_add;
   logic                        lead;

   assign digit    = hdc_pkg::hex_value(rx_byte);
   assign is_digit = !digit[4];
   // saturate once another digit would pass the largest magnitude
   assign acc_add  = (acc[30:27] != 4'd0) ? hdc_pkg::SIZE_MAX_MAG : {acc[26:0], digit[3:0]};

   always_comb begin
      step_out     = step;
      acc_out      = acc;
      negative_out = negative;
      lead         = 1'b0;
      case (step)
         hdc_pkg::PS_BLANK: begin
            if (hdc_pkg::is_blank(rx_byte)) begin
               step_out = hdc_pkg::PS_BLANK;
            end else if (rx_byte == 8'h2B) begin
               step_out = hdc_pkg::PS_SIGN;
            end else if (rx_byte == 8'h2D) begin
               negative_out = 1'b1;
               step_out     = hdc_pkg::PS_SIGN;
            end else begin
               lead = 1'b1;
            end
         end
         hdc_pkg::PS_SIGN: begin
            lead = 1'b1;
         end
         hdc_pkg::PS_ZERO: begin
            if (rx_byte == 8'h78 || rx_byte == 8'h58) begin
               step_out = hdc_pkg::PS_PREFIX;
            end else if (is_digit) begin
               acc_out  = acc_add;
               step_out = hdc_pkg::PS_DIGITS;
            end else begin
               step_out = hdc_pkg::PS_STOP;
            end
         end
         hdc_pkg::PS_PREFIX, hdc_pkg::PS_DIGITS: begin
            if (is_digit) begin
               acc_out  = acc_add;
               step_out = hdc_pkg::PS_DIGITS;
            end else begin
               step_out = hdc_pkg::PS_STOP;
            end
         end
         default: begin
            step_out = step;
         end
      endcase
      if (lead) begin
         if (rx_byte == 8'h30) begin
            step_out = hdc_pkg::PS_ZERO;
         end else if (is_digit) begin
            acc_out  = acc_add;
            step_out = hdc_pkg::PS_DIGITS;
         end else begin
            step_out = hdc_pkg::PS_STOP;
         end
      end
   end

endmodule

// ===== design/hdc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_core: framing state and result register
// Config registers, body framing state, one-step update and the rsp stage.
// ----------------------------------------------------------------------------
module hdc_core #(
   parameter int LINE_LIMIT = hdc_pkg::LINE_LIMIT_DEF,
   parameter int COUNT_BITS = hdc_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              beat_valid,
   input  hdc_pkg::req_beat_type             beat,
   output logic                              beat_ready,
   input  logic                              csr_valid,
   input  logic [hdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hdc_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_status,
   output logic [7:0]                        rsp_body_byte,
   output logic                              rsp_last_byte,
   output logic [31:0]                       rsp_bytes_consumed,
   output logic                              rsp_finished
);

   localparam int LINE_W = $clog2(LINE_LIMIT + 2);
   localparam int LEN_W  = hdc_pkg::LEN_W;

   // configuration
   logic [1:0]        mode_ff, mode_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              restart;

   // framing state
   hdc_pkg::phase_type phase_ff, phase_in;
   hdc_pkg::step_type  step_ff, step_in, step_p;
   logic [LEN_W-1:0]   left_ff, left_in, left_dec;
   logic [LEN_W-1:0]   acc_ff, acc_in, acc_p;
   logic [LINE_W-1:0]  len_ff, len_in, len_inc;
   logic               neg_ff, neg_in, neg_p;
   logic               skip_ff, skip_in;
   logic               fcr_ff, fcr_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic               done_ff, done_in;

   // result stage
   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_c;
   logic [7:0]  body_ff, body_c;
   logic        last_ff, last_c;
   logic [31:0] count_ff;
   logic        fin_ff;

   logic fire;
   logic empty_line;
   logic line_over;
   logic is_lf;

   assign beat_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = beat_valid && beat_ready;

   assign restart   = csr_valid && (csr_index == hdc_pkg::CSR_FRAMING_MODE ||
                                    csr_index == hdc_pkg::CSR_BODY_LENGTH);
   assign mode_in   = (csr_index == hdc_pkg::CSR_FRAMING_MODE) ? csr_data[1:0] : mode_ff;
   assign length_in = (csr_index == hdc_pkg::CSR_BODY_LENGTH) ? csr_data : length_ff;

   assign left_dec   = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   assign len_inc    = len_ff + 1'b1;
   assign line_over  = len_inc > LINE_W'(LINE_LIMIT);
   assign empty_line = (len_ff == '0) || (len_ff == LINE_W'(1) && fcr_ff);
   assign is_lf      = beat.data == hdc_pkg::CH_LF;

   hdc_size_parse u_size_parse (
      .step         (step_ff),
      .acc          (acc_ff),
      .negative     (neg_ff),
      .rx_byte      (beat.data),
      .step_out     (step_p),
      .acc_out      (acc_p),
      .negative_out (neg_p)
   );

   // next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;
      neg_in   = neg_ff;
      skip_in  = skip_ff;
      fcr_in   = fcr_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      if (!done_ff) begin
         if (beat.op == hdc_pkg::OP_CLOSE) begin
            done_in = 1'b1;
         end else if (phase_ff == hdc_pkg::PH_DATA) begin
            cnt_in = cnt_ff + 1'b1;
            if (mode_ff == hdc_pkg::MODE_FIXED) begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  done_in = 1'b1;
               end
            end else if (mode_ff == hdc_pkg::MODE_CHUNKED) begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = hdc_pkg::PH_LINE;
                  skip_in  = 1'b0;
                  len_in   = '0;
                  fcr_in   = 1'b0;
                  acc_in   = '0;
                  neg_in   = 1'b0;
                  step_in  = hdc_pkg::PS_BLANK;
               end
            end
         end else if (is_lf) begin
            if (phase_ff == hdc_pkg::PH_LINE) begin
               if (empty_line && !skip_ff) begin
                  // CRLF that trails the previous chunk's data
                  skip_in = 1'b1;
               end else if (!neg_ff && acc_ff != '0) begin
                  left_in  = acc_ff;
                  phase_in = hdc_pkg::PH_DATA;
                  skip_in  = 1'b0;
               end else begin
                  phase_in = hdc_pkg::PH_TRAILER;
               end
            end else if (empty_line) begin
               done_in = 1'b1;
            end
            len_in  = '0;
            fcr_in  = 1'b0;
            acc_in  = '0;
            neg_in  = 1'b0;
            step_in = hdc_pkg::PS_BLANK;
         end else begin
            if (len_ff == '0) begin
               fcr_in = beat.data == hdc_pkg::CH_CR;
            end
            len_in = len_inc;
            if (line_over) begin
               done_in = 1'b1;
            end else if (phase_ff == hdc_pkg::PH_LINE) begin
               step_in = step_p;
               acc_in  = acc_p;
               neg_in  = neg_p;
            end
         end
      end
   end

   // result of this beat
   always_comb begin
      status_c = hdc_pkg::ST_NONE;
      body_c   = 8'd0;
      last_c   = 1'b0;
      if (!done_ff) begin
         if (beat.op == hdc_pkg::OP_CLOSE) begin
            status_c = (mode_ff[1] && phase_ff == hdc_pkg::PH_DATA) ?
                       hdc_pkg::ST_COMPLETE : hdc_pkg::ST_ABORT;
         end else if (phase_ff == hdc_pkg::PH_DATA) begin
            status_c = hdc_pkg::ST_BODY;
            body_c   = beat.data;
            last_c   = (mode_ff == hdc_pkg::MODE_FIXED) && (left_dec == '0);
         end else if (is_lf) begin
            if (phase_ff == hdc_pkg::PH_TRAILER && empty_line) begin
               status_c = hdc_pkg::ST_COMPLETE;
            end
         end else if (line_over) begin
            status_c = hdc_pkg::ST_ABORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= hdc_pkg::MODE_FIXED;
         length_ff <= '0;
         phase_ff  <= hdc_pkg::PH_DATA;
         step_ff   <= hdc_pkg::PS_BLANK;
         left_ff   <= '0;
         acc_ff    <= '0;
         len_ff    <= '0;
         neg_ff    <= 1'b0;
         skip_ff   <= 1'b0;
         fcr_ff    <= 1'b0;
         cnt_ff    <= '0;
         done_ff   <= 1'b1;
      end else if (restart) begin
         mode_ff   <= mode_in;
         length_ff <= length_in;
         phase_ff  <= (mode_in == hdc_pkg::MODE_CHUNKED) ? hdc_pkg::PH_LINE : hdc_pkg::PH_DATA;
         step_ff   <= hdc_pkg::PS_BLANK;
         left_ff   <= (mode_in == hdc_pkg::MODE_FIXED) ? length_in : '0;
         acc_ff    <= '0;
         len_ff    <= '0;
         neg_ff    <= 1'b0;
         skip_ff   <= 1'b0;
         fcr_ff    <= 1'b0;
         cnt_ff    <= '0;
         done_ff   <= (mode_in == hdc_pkg::MODE_FIXED) && (length_in == '0);
      end else if (fire) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
         len_ff   <= len_in;
         neg_ff   <= neg_in;
         skip_ff  <= skip_in;
         fcr_ff   <= fcr_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_c;
         body_ff   <= body_c;
         last_ff   <= last_c;
         count_ff  <= 32'(cnt_in);
         fin_ff    <= done_in;
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_body_byte      = body_ff;
   assign rsp_last_byte      = last_ff;
   assign rsp_bytes_consumed = count_ff;
   assign rsp_finished       = fin_ff;

endmodule

// ===== design/http_body_dechunker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_body_dechunker_top: HTTP response body framer
// Delimits a body by fixed length, chunked coding or connection close.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: rx_byte; tuser: operation
//  rsp     | out | rsp_tvalid/tready    | tdata: body_byte, bytes_consumed;
//          |     |                      | tuser: status, finished; tlast
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One beat per cycle sustained while rsp is ready; each beat passes the input
// register, then the framing update into the result register.
// Reset leaves fixed-length mode with length zero, so the body reads as
// finished until a register write restarts framing. csr_ready is always high.
// A stalled rsp holds its beat; the input register takes one more beat,
// then req_tready drops until rsp drains.
module http_body_dechunker_top #(
   parameter int LINE_LIMIT = hdc_pkg::LINE_LIMIT_DEF,
   parameter int COUNT_BITS = hdc_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   input  logic                            req_tuser,  // [0] operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,  // [7:0] body_byte, [39:8] bytes_consumed
   output logic [2:0]                      rsp_tuser,  // [1:0] status, [2] finished
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hdc_pkg::CSR_DATA_W-1:0]  csr_data
);

   hdc_pkg::req_beat_type req_beat;
   hdc_pkg::req_beat_type beat;
   logic                  beat_valid;
   logic                  beat_ready;
   logic [1:0]            status;
   logic [7:0]            body_byte;
   logic [31:0]           bytes_consumed;
   logic                  finished;

   assign req_beat.op   = req_tuser;
   assign req_beat.data = req_tdata;
   assign csr_ready     = 1'b1;

   hdc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_beat   (req_beat),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   hdc_core #(
      .LINE_LIMIT (LINE_LIMIT),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .beat_valid         (beat_valid),
      .beat               (beat),
      .beat_ready         (beat_ready),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_status         (status),
      .rsp_body_byte      (body_byte),
      .rsp_last_byte      (rsp_tlast),
      .rsp_bytes_consumed (bytes_consumed),
      .rsp_finished       (finished)
   );

   assign rsp_tdata = {bytes_consumed, body_byte};
   assign rsp_tuser = {finished, status};

endmodule

// ===== design/hdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_checker: port-level checks for the HTTP body dechunker
// Watches the rsp channel against reset and the framing codes.
// ----------------------------------------------------------------------------
module hdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // nothing in flight right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // complete and abort always end the body
   a_end_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == hdc_pkg::ST_COMPLETE ||
                     rsp_tuser[1:0] == hdc_pkg::ST_ABORT) |-> rsp_tuser[2])
      else $error("end status without finished");

   // last byte only on a body byte that finishes the body
   a_last_body: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] == hdc_pkg::ST_BODY && rsp_tuser[2])
      else $error("tlast on a non-final beat");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

endmodule

bind http_body_dechunker_top hdc_checker u_hdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
